### hdl/apgd_pkg.sv
// ----------------------------------------------------------------------------
// apgd_pkg: shared types and constants
// Types, fixed constants and the CORDIC arctangent table for the pickup
// gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none
package apgd_pkg;

  localparam int AXIS_W     = 16;
  localparam int PITCH_W    = 14;
  localparam int SQ_W       = 32;
  localparam int RAD_W      = 48;
  localparam int ROOT_W     = 24;
  localparam int REM_W      = 26;
  localparam int CX_W       = 36;
  localparam int ZACC_W     = 24;
  localparam int TAB_W      = 23;
  localparam int TAB_IDX_W  = 5;
  localparam int SQRT_ITERS = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [PITCH_W-1:0] ANGLE_MAX = 14'sd5760;

  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REST_DELTA   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PITCH_BOTTOM = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PITCH_TOP    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROLL_LIMIT   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_AXIS_LOW     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_AXIS_HIGH    = 3'd6;

  localparam logic [15:0]        RST_TIMEOUT      = 16'd750;
  localparam logic [14:0]        RST_REST_DELTA   = 15'd179;
  localparam logic [12:0]        RST_PITCH_BOTTOM = 13'd1280;
  localparam logic [12:0]        RST_PITCH_TOP    = 13'd5568;
  localparam logic [12:0]        RST_ROLL_LIMIT   = 13'd640;
  localparam logic signed [15:0] RST_AXIS_LOW     = 16'sd1024;
  localparam logic signed [15:0] RST_AXIS_HIGH    = 16'sd2560;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_COMMIT
  } top_state_t;

  typedef enum logic [2:0] {
    AU_IDLE,
    AU_SQA,
    AU_SQB,
    AU_SQRT,
    AU_CORD,
    AU_DONE
  } au_state_t;

  typedef struct packed {
    logic                     start;
    logic signed [AXIS_W-1:0] num;
    logic signed [AXIS_W-1:0] a;
    logic signed [AXIS_W-1:0] b;
  } angle_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic signed [PITCH_W-1:0] angle;
  } angle_rsp_t;

  // atan(2^-i) in degrees, scaled by 65536
  function automatic logic [TAB_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
    logic [TAB_W-1:0] v;
    unique case (idx)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hdl/apgd_angle_unit.sv
// ----------------------------------------------------------------------------
// apgd_angle_unit: iterative arctangent unit
// atan(num / sqrt(a^2 + b^2)) in 1/64 degree: one shared multiplier for the
// squares, a two-bit-per-cycle square root, then a vectoring CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none
module apgd_angle_unit #(
  parameter int CORDIC_STEPS = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire apgd_pkg::angle_req_t  req,
  output apgd_pkg::angle_rsp_t       rsp
);

  localparam int CNT_W = $clog2(apgd_pkg::SQRT_ITERS);

  apgd_pkg::au_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [apgd_pkg::AXIS_W-1:0] num_r, a_r, b_r;
  logic [apgd_pkg::SQ_W-1:0] sq_r, sq_nxt;
  logic [apgd_pkg::RAD_W-1:0] rad_r, rad_nxt;
  logic [apgd_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [apgd_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic signed [apgd_pkg::CX_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [apgd_pkg::ZACC_W-1:0] z_r, z_nxt;
  logic signed [apgd_pkg::PITCH_W-1:0] angle_r, angle_nxt;

  logic signed [apgd_pkg::AXIS_W-1:0] mop;
  logic signed [apgd_pkg::SQ_W-1:0] prod;
  logic [apgd_pkg::SQ_W-1:0] sq_sum;
  logic [apgd_pkg::REM_W-1:0] rem_sh, trial;
  logic rt_ge;
  logic signed [apgd_pkg::CX_W-1:0] dx, dy;
  logic signed [apgd_pkg::ZACC_W-1:0] tab_v, z_rnd;
  logic sq_last, cord_last;

  assign mop    = (state_r == apgd_pkg::AU_SQA) ? a_r : b_r;
  assign prod   = mop * mop;
  assign sq_sum = sq_r + unsigned'(prod);
  assign rem_sh = {rem_r[apgd_pkg::REM_W-3:0], rad_r[apgd_pkg::RAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign rt_ge  = rem_sh >= trial;
  assign dx     = y_r >>> cnt_r;
  assign dy     = x_r >>> cnt_r;
  assign tab_v  = apgd_pkg::ZACC_W'(signed'({1'b0,
                    apgd_pkg::atan_entry(apgd_pkg::TAB_IDX_W'(cnt_r))}));
  assign sq_last   = cnt_r == CNT_W'(apgd_pkg::SQRT_ITERS - 1);
  assign cord_last = cnt_r == CNT_W'(CORDIC_STEPS - 1);
  assign z_rnd     = (z_nxt + apgd_pkg::ZACC_W'(512)) >>> 10;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      apgd_pkg::AU_IDLE: if (req.start) state_nxt = apgd_pkg::AU_SQA;
      apgd_pkg::AU_SQA:  state_nxt = apgd_pkg::AU_SQB;
      apgd_pkg::AU_SQB: begin
        if (sq_sum == '0 && num_r == '0) state_nxt = apgd_pkg::AU_DONE;
        else state_nxt = apgd_pkg::AU_SQRT;
      end
      apgd_pkg::AU_SQRT: if (sq_last) state_nxt = apgd_pkg::AU_CORD;
      apgd_pkg::AU_CORD: if (cord_last) state_nxt = apgd_pkg::AU_DONE;
      apgd_pkg::AU_DONE: state_nxt = apgd_pkg::AU_IDLE;
      default:           state_nxt = apgd_pkg::AU_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.busy  = state_r != apgd_pkg::AU_IDLE;
    rsp.done  = state_r == apgd_pkg::AU_DONE;
    rsp.angle = angle_r;
  end

  // datapath
  always_comb begin
    cnt_nxt   = cnt_r;
    sq_nxt    = sq_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    angle_nxt = angle_r;
    unique case (state_r)
      apgd_pkg::AU_SQA: sq_nxt = unsigned'(prod);
      apgd_pkg::AU_SQB: begin
        sq_nxt    = sq_sum;
        rad_nxt   = {sq_sum, 16'h0000};
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
        angle_nxt = '0;
      end
      apgd_pkg::AU_SQRT: begin
        rem_nxt  = rt_ge ? (rem_sh - trial) : rem_sh;
        root_nxt = {root_r[apgd_pkg::ROOT_W-2:0], rt_ge};
        rad_nxt  = rad_r << 2;
        cnt_nxt  = cnt_r + 1'b1;
        if (sq_last) begin
          cnt_nxt = '0;
          x_nxt   = signed'({4'b0000, root_nxt, 8'h00});
          y_nxt   = signed'({{4{num_r[apgd_pkg::AXIS_W-1]}}, num_r, 16'h0000});
          z_nxt   = '0;
        end
      end
      apgd_pkg::AU_CORD: begin
        if (!y_r[apgd_pkg::CX_W-1]) begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + tab_v;
        end else begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - tab_v;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cord_last) begin
          if (z_rnd > apgd_pkg::ZACC_W'(apgd_pkg::ANGLE_MAX)) begin
            angle_nxt = apgd_pkg::ANGLE_MAX;
          end else if (z_rnd < -apgd_pkg::ZACC_W'(apgd_pkg::ANGLE_MAX)) begin
            angle_nxt = -apgd_pkg::ANGLE_MAX;
          end else begin
            angle_nxt = z_rnd[apgd_pkg::PITCH_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apgd_pkg::AU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == apgd_pkg::AU_IDLE && req.start) begin
      num_r <= req.num;
      a_r   <= req.a;
      b_r   <= req.b;
    end
    cnt_r   <= cnt_nxt;
    sq_r    <= sq_nxt;
    rad_r   <= rad_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    angle_r <= angle_nxt;
  end

endmodule
`default_nettype wire

### hdl/accel_pickup_gesture_detector_core.sv
// A sample, and a tick that expires the countdown, passes through the shared angle
// unit (the squares, the square root, then the CORDIC steps) before its result is
// committed; other ticks go straight to commit. The next transaction is taken only after
// the commit, which waits while an earlier result is still unaccepted on out_tready.
// Reset (rst_n, synchronous) restores the configuration registers and detector
// state to their defaults.
// ----------------------------------------------------------------------------
// accel_pickup_gesture_detector_core: pickup gesture detector
// Pitch, rest and z-sign tracking, arming countdown and expiry evaluation.
// ----------------------------------------------------------------------------
`default_nettype none
module accel_pickup_gesture_detector_core #(
  parameter int HIST_DEPTH   = 6,
  parameter int CORDIC_STEPS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  input  wire logic        in_tuser,  // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // pickup, timer_expired, pitch_now[15:2],
                                      // armed, resting, zero fill
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int HC_W = $clog2(HIST_DEPTH + 1);
  localparam logic [HC_W-1:0] HC_MAX = HC_W'(HIST_DEPTH - 1);

  apgd_pkg::top_state_t state_r, state_nxt;

  logic [15:0]        timeout_r;
  logic [14:0]        rest_delta_r;
  logic [12:0]        pitch_bottom_r, pitch_top_r, roll_limit_r;
  logic signed [15:0] axis_low_r, axis_high_r;

  logic               kind_r;
  logic signed [15:0] x_r, y_r, z_r;

  logic signed [15:0] px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic signed [13:0] pitch_r, pitch_nxt, pref_r, pref_nxt;
  logic detect_r, detect_nxt, sok_r, sok_nxt, rest_r, rest_nxt;
  logic run_r, run_nxt;
  logic [HIST_DEPTH-1:0] hist_r, hist_nxt;
  logic [HC_W-1:0] zc_r, zc_nxt, nac_r, nac_nxt;
  logic [15:0] cd_r, cd_nxt;

  logic        out_valid_r;
  logic [17:0] out_data_r;
  logic        pickup_c, expired_c;

  apgd_pkg::angle_req_t areq;
  apgd_pkg::angle_rsp_t arsp;

  logic accept, need_angle, commit, slot_free;

  assign accept     = in_tvalid && in_tready;
  assign need_angle = !in_tuser || (run_r && cd_r == 16'd1);
  assign slot_free  = !out_valid_r || out_tready;
  assign commit     = state_r == apgd_pkg::ST_COMMIT && slot_free;

  always_comb begin
    areq.start = accept && need_angle;
    if (!in_tuser) begin
      areq.num = signed'(in_tdata[31:16]);
      areq.a   = signed'(in_tdata[15:0]);
      areq.b   = signed'(in_tdata[47:32]);
    end else begin
      areq.num = px_r;
      areq.a   = py_r;
      areq.b   = pz_r;
    end
  end

  apgd_angle_unit #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_angle (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (areq),
    .rsp  (arsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      apgd_pkg::ST_IDLE: begin
        if (accept) state_nxt = need_angle ? apgd_pkg::ST_CALC : apgd_pkg::ST_COMMIT;
      end
      apgd_pkg::ST_CALC:   if (arsp.done) state_nxt = apgd_pkg::ST_COMMIT;
      apgd_pkg::ST_COMMIT: if (slot_free) state_nxt = apgd_pkg::ST_IDLE;
      default:             state_nxt = apgd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = state_r == apgd_pkg::ST_IDLE;
    out_tvalid = out_valid_r;
    out_tdata  = {6'b0, out_data_r};
  end

  // detector update
  logic [16:0] adx, ady, adz, rd17;
  logic signed [16:0] ddx, ddy, ddz;
  logic [HC_W-1:0] zc_c, nac_c;
  logic signed [14:0] prise;
  logic arm_ok, rest_s, d_s;
  logic [HIST_DEPTH-1:0] mask;
  logic [12:0] roll_abs;
  logic eval_ok;
  logic [15:0] cd_dec;

  always_comb begin
    ddx  = {px_r[15], px_r} - {x_r[15], x_r};
    ddy  = {py_r[15], py_r} - {y_r[15], y_r};
    ddz  = {pz_r[15], pz_r} - {z_r[15], z_r};
    adx  = ddx[16] ? unsigned'(-ddx) : unsigned'(ddx);
    ady  = ddy[16] ? unsigned'(-ddy) : unsigned'(ddy);
    adz  = ddz[16] ? unsigned'(-ddz) : unsigned'(ddz);
    rd17 = {2'b00, rest_delta_r};
    zc_c  = (zc_r > HC_MAX) ? HC_MAX : zc_r;
    nac_c = (nac_r > HC_MAX) ? HC_MAX : nac_r;
    prise = {arsp.angle[13], arsp.angle} - {pref_r[13], pref_r};
    for (int k = 0; k < HIST_DEPTH; k++) begin
      mask[k] = (HC_W + 1)'(k + 1) < {1'b0, zc_r};
    end
    roll_abs = arsp.angle[13] ? 13'(-arsp.angle) : arsp.angle[12:0];
    eval_ok = ((hist_r & mask) == '0) && (nac_r < HC_W'(2)) && detect_r && sok_r
              && (roll_abs < roll_limit_r)
              && (pitch_r < signed'({1'b0, pitch_top_r}))
              && (pitch_r > signed'({1'b0, pitch_bottom_r}))
              && (py_r > axis_low_r) && (py_r < axis_high_r)
              && (pz_r > axis_low_r) && (pz_r < axis_high_r);
    cd_dec = cd_r - 16'd1;

    px_nxt = px_r; py_nxt = py_r; pz_nxt = pz_r;
    pitch_nxt = pitch_r; pref_nxt = pref_r;
    detect_nxt = detect_r; sok_nxt = sok_r; rest_nxt = rest_r;
    run_nxt = run_r; hist_nxt = hist_r; zc_nxt = zc_r; nac_nxt = nac_r;
    cd_nxt = cd_r;
    pickup_c = 1'b0; expired_c = 1'b0;
    rest_s = 1'b0; d_s = 1'b0; arm_ok = 1'b0;

    if (!kind_r) begin
      pitch_nxt = arsp.angle;
      rest_s = (adx < rd17) && (ady < rd17) && (adz < rd17);
      d_s = detect_r;
      zc_nxt = zc_c;
      nac_nxt = nac_c;
      if (!detect_r) begin
        hist_nxt = {hist_r[HIST_DEPTH-2:0], z_r[15]};
        zc_nxt = zc_c + 1'b1;
      end
      if (detect_r && z_r[15]) begin
        sok_nxt = 1'b0;
        d_s = 1'b0;
        nac_nxt = nac_c + 1'b1;
        rest_s = 1'b1;
      end
      arm_ok = !rest_s && !d_s && (prise > signed'({2'b00, pitch_bottom_r}));
      if (arm_ok) begin
        d_s = 1'b1;
        if (!run_r) begin
          cd_nxt = (timeout_r == '0) ? 16'd1 : timeout_r;
          run_nxt = 1'b1;
        end
        pref_nxt = arsp.angle;
        sok_nxt = 1'b1;
      end
      px_nxt = x_r; py_nxt = y_r; pz_nxt = z_r;
      if (rest_s && !d_s) pref_nxt = arsp.angle;
      rest_nxt = rest_s;
      detect_nxt = d_s;
    end else if (run_r) begin
      cd_nxt = cd_dec;
      if (cd_dec == '0) begin
        run_nxt = 1'b0;
        expired_c = 1'b1;
        pickup_c = eval_ok;
        sok_nxt = 1'b0;
        detect_nxt = 1'b0;
        nac_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= apgd_pkg::ST_IDLE;
      timeout_r      <= apgd_pkg::RST_TIMEOUT;
      rest_delta_r   <= apgd_pkg::RST_REST_DELTA;
      pitch_bottom_r <= apgd_pkg::RST_PITCH_BOTTOM;
      pitch_top_r    <= apgd_pkg::RST_PITCH_TOP;
      roll_limit_r   <= apgd_pkg::RST_ROLL_LIMIT;
      axis_low_r     <= apgd_pkg::RST_AXIS_LOW;
      axis_high_r    <= apgd_pkg::RST_AXIS_HIGH;
      px_r <= '0; py_r <= '0; pz_r <= '0;
      pitch_r <= '0; pref_r <= '0;
      detect_r <= 1'b0; sok_r <= 1'b1; rest_r <= 1'b1; run_r <= 1'b0;
      hist_r <= '0; zc_r <= '0; nac_r <= '0; cd_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          apgd_pkg::CFG_TIMEOUT:      timeout_r      <= cfg_wdata;
          apgd_pkg::CFG_REST_DELTA:   rest_delta_r   <= cfg_wdata[14:0];
          apgd_pkg::CFG_PITCH_BOTTOM: pitch_bottom_r <= cfg_wdata[12:0];
          apgd_pkg::CFG_PITCH_TOP:    pitch_top_r    <= cfg_wdata[12:0];
          apgd_pkg::CFG_ROLL_LIMIT:   roll_limit_r   <= cfg_wdata[12:0];
          apgd_pkg::CFG_AXIS_LOW:     axis_low_r     <= signed'(cfg_wdata);
          apgd_pkg::CFG_AXIS_HIGH:    axis_high_r    <= signed'(cfg_wdata);
          default: ;
        endcase
      end
      if (commit) begin
        px_r <= px_nxt; py_r <= py_nxt; pz_r <= pz_nxt;
        pitch_r <= pitch_nxt; pref_r <= pref_nxt;
        detect_r <= detect_nxt; sok_r <= sok_nxt; rest_r <= rest_nxt;
        run_r <= run_nxt; hist_r <= hist_nxt; zc_r <= zc_nxt; nac_r <= nac_nxt;
        cd_r <= cd_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_tuser;
      x_r    <= signed'(in_tdata[15:0]);
      y_r    <= signed'(in_tdata[31:16]);
      z_r    <= signed'(in_tdata[47:32]);
    end
    if (commit) begin
      out_data_r <= {rest_nxt, detect_nxt, pitch_nxt, expired_c, pickup_c};
    end
  end

`ifndef SYNTHESIS
  a_cd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> cd_r != '0)
    else $error("countdown running at zero");
  a_nac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nac_r <= HC_W'(HIST_DEPTH))
    else $error("abort count out of range");
  a_expire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[1] |-> !out_data_r[16])
    else $error("armed after expiry");
  a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == apgd_pkg::ST_IDLE |-> !arsp.busy)
    else $error("angle unit busy while idle");
`endif

endmodule
`default_nettype wire

### tb/sv/apgd_checker.sv
// ----------------------------------------------------------------------------
// apgd_checker: result predictor and comparator for the pickup detector
// Watches the sample/tick channel, the register port and the result channel.
// Each accepted transaction updates a local copy of the detector state and
// queues the expected result. Each result transaction is compared field by
// field against the oldest queued result.
// ----------------------------------------------------------------------------
module apgd_checker
  import apgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          errors,
  output int          pending
);
  localparam int HIST = 6;
  localparam int STEPS = 14;

  typedef struct packed {
    logic                pickup;
    logic                expired;
    logic signed [13:0]  pitch;
    logic                armed;
    logic                resting;
  } gesture_res_t;

  gesture_res_t res_q[$];

  int unsigned r_timeout, r_rest, r_bottom, r_top, r_roll;
  int r_low, r_high;
  int px, py, pz, pitch_cur, pitch_ref;
  bit detect, sig_ok, rest, run;
  int unsigned zhist, zcnt, aborts, cdown;

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic int tilt_angle(int num, int a, int b);
    longint unsigned s;
    longint x, y, z, dx, dy, r;
    s = longint'(a) * a + longint'(b) * b;
    if (s == 0 && num == 0) return 0;
    x = longint'(int_sqrt(s << 16) << 8);
    y = longint'(num) * 65536;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(atan_entry(i[4:0]));
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(atan_entry(i[4:0]));
      end
    end
    r = (z + 512) >>> 10;
    if (r > 5760) r = 5760;
    if (r < -5760) r = -5760;
    return int'(r);
  endfunction

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void take_sample(int x, int y, int z);
    int rd;
    rd = int'(r_rest);
    pitch_cur = tilt_angle(y, x, z);
    if (zcnt > HIST - 1) zcnt = HIST - 1;
    rest = iabs(px - x) < rd && iabs(py - y) < rd && iabs(pz - z) < rd;
    if (aborts > HIST - 1) aborts = HIST - 1;
    if (!detect) begin
      zhist = ((zhist << 1) | (z < 0 ? 1 : 0)) & ((1 << HIST) - 1);
      zcnt++;
    end
    if (detect && z < 0) begin
      sig_ok = 0; detect = 0; aborts++; rest = 1;
    end
    if (!rest && !detect && pitch_cur - pitch_ref > int'(r_bottom)) begin
      detect = 1;
      if (!run) begin
        cdown = r_timeout == 0 ? 1 : r_timeout;
        run = 1;
      end
      pitch_ref = pitch_cur;
      sig_ok = 1;
    end
    px = x; py = y; pz = z;
    if (rest && !detect) pitch_ref = pitch_cur;
  endfunction

  function automatic bit pickup_ok();
    int roll;
    int unsigned mask;
    roll = tilt_angle(px, py, pz);
    mask = zcnt >= 2 ? ((1 << (zcnt - 1)) - 1) : 0;
    return (zhist & mask) == 0 && aborts < 2 && detect && sig_ok &&
           iabs(roll) < int'(r_roll) && pitch_cur < int'(r_top) &&
           pitch_cur > int'(r_bottom) && py > r_low && py < r_high &&
           pz > r_low && pz < r_high;
  endfunction

  function automatic gesture_res_t step_detector(bit tick, int x, int y, int z);
    gesture_res_t e;
    e = '0;
    if (!tick) begin
      take_sample(x, y, z);
    end else if (run) begin
      cdown = (cdown - 1) & 16'hFFFF;
      if (cdown == 0) begin
        run = 0;
        e.expired = 1;
        e.pickup = pickup_ok();
        sig_ok = 0; detect = 0; aborts = 0;
      end
    end
    e.pitch = pitch_cur[13:0];
    e.armed = detect;
    e.resting = rest;
    return e;
  endfunction

  gesture_res_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      r_timeout = RST_TIMEOUT; r_rest = RST_REST_DELTA; r_bottom = RST_PITCH_BOTTOM;
      r_top = RST_PITCH_TOP; r_roll = RST_ROLL_LIMIT;
      r_low = RST_AXIS_LOW; r_high = RST_AXIS_HIGH;
      px = 0; py = 0; pz = 0; pitch_cur = 0; pitch_ref = 0;
      detect = 0; sig_ok = 1; rest = 1; run = 0;
      zhist = 0; zcnt = 0; aborts = 0; cdown = 0;
      res_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TIMEOUT:      r_timeout = cfg_wdata;
          CFG_REST_DELTA:   r_rest = cfg_wdata[14:0];
          CFG_PITCH_BOTTOM: r_bottom = cfg_wdata[12:0];
          CFG_PITCH_TOP:    r_top = cfg_wdata[12:0];
          CFG_ROLL_LIMIT:   r_roll = cfg_wdata[12:0];
          CFG_AXIS_LOW:     r_low = int'($signed(cfg_wdata));
          CFG_AXIS_HIGH:    r_high = int'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        res_q.push_back(step_detector(in_tuser, int'($signed(in_tdata[15:0])),
                                      int'($signed(in_tdata[31:16])),
                                      int'($signed(in_tdata[47:32]))));
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[1], out_tdata[15:2], out_tdata[16], out_tdata[17]};
        if (res_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction %h", out_tdata);
        end else begin
          want = res_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: pickup %0d/%0d expired %0d/%0d pitch %0d/%0d armed %0d/%0d rest %0d/%0d",
                       want.pickup, got.pickup, want.expired, got.expired, want.pitch,
                       got.pitch, want.armed, got.armed, want.resting, got.resting);
          end
        end
      end
    end
    pending = res_q.size();
  end
endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: pickup gesture detector testbench
// Drives samples and ticks with random gaps, random result back-pressure and
// one long hold-off. Runs directed gestures, then random gestures and noise
// over several register settings including the extremes.
// ----------------------------------------------------------------------------
module tb;
  import apgd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  int          errors;
  int          pending;
  int          cycles;
  bit          hold_off;
  int unsigned cur_timeout;

  accel_pickup_gesture_detector_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  apgd_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 600000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 0;
      else if (cycles % 2000 < 500) out_tready <= 1;
      else out_tready <= ($urandom_range(0, 99) < 70);
    end
  end

  initial begin
    hold_off = 0;
    wait (cycles > 3000);
    @(negedge clk);
    hold_off = 1;
    repeat (400) @(negedge clk);
    hold_off = 0;
  end

  task automatic send(bit tick, int x, int y, int z);
    int gap;
    gap = (cycles % 3000 < 600) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= tick;
    in_tdata <= {z[15:0], y[15:0], x[15:0]};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic idle_out();
    in_tvalid <= 0;
    wait (pending == 0);
    repeat (60) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [15:0] val);
    cfg_we <= 1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (addr == CFG_TIMEOUT) cur_timeout = (val == 0) ? 1 : val;
  endtask

  task automatic ticks(int n);
    repeat (n) send(1, $urandom, $urandom, $urandom);
  endtask

  // rest, lift, up to two more lifted samples, then ticks (through the countdown when it is short)
  task automatic gesture();
    int x, y, z, n;
    x = $urandom_range(0, 400) - 200;
    y = $urandom_range(0, 600) - 300;
    z = $urandom_range(1000, 2600);
    send(0, x, y, z);
    send(0, x, y, z);
    y = $urandom_range(900, 2700);
    z = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(1, 2000)) : $urandom_range(900, 2700);
    send(0, $urandom_range(0, 600) - 300, y, z);
    n = $urandom_range(0, 2);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) z = -int'($urandom_range(1, 3000));
      else z = $urandom_range(900, 2700);
      send(0, $urandom_range(0, 600) - 300, $urandom_range(900, 2700), z);
    end
    if (cur_timeout <= 16) ticks(cur_timeout + $urandom_range(0, 1));
    else ticks($urandom_range(1, 4));
  endtask

  task automatic random_part(int n);
    int done_n;
    done_n = 0;
    while (done_n < n) begin
      if ($urandom_range(0, 99) < 65) begin
        gesture();
        done_n += 5;
      end else begin
        if ($urandom_range(0, 2) == 0) send(1, $urandom, $urandom, $urandom);
        else send(0, $signed($urandom), $signed($urandom), $signed($urandom));
        done_n++;
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = '0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    cur_timeout = RST_TIMEOUT;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed, reset settings apart from a short countdown
    send(1, 0, 0, 0);
    send(0, 0, 0, 0);
    send(0, -32768, -32768, -32768);
    send(0, 32767, 32767, 32767);
    send(0, 0, 32767, 0);
    send(0, 0, -32768, 0);
    idle_out();
    reg_write(CFG_TIMEOUT, 16'd3);
    send(0, 0, 0, 2000);
    send(0, 0, 0, 2000);
    send(0, 0, 2000, 1500);
    ticks(3);
    send(0, 0, 0, 2000);
    send(0, 0, 0, 2000);
    send(0, 0, 2000, 1500);
    send(0, 0, 2000, -1500);
    send(0, 0, 2200, 1500);
    ticks(4);
    send(0, 0, -2000, 1500);
    send(0, 0, 2000, 1500);
    send(0, 0, 0, 2000);
    send(0, 0, 2400, 1200);
    ticks(3);
    random_part(60);
    idle_out();

    // wide-open thresholds, zero timeout
    reg_write(CFG_TIMEOUT, 16'd0);
    reg_write(CFG_REST_DELTA, 16'd32767);
    reg_write(CFG_PITCH_BOTTOM, 16'd0);
    reg_write(CFG_PITCH_TOP, 16'd5760);
    reg_write(CFG_ROLL_LIMIT, 16'd5760);
    reg_write(CFG_AXIS_LOW, 16'h8000);
    reg_write(CFG_AXIS_HIGH, 16'h7FFF);
    random_part(60);
    idle_out();

    // closed thresholds, longest countdown
    reg_write(CFG_TIMEOUT, 16'hFFFF);
    reg_write(CFG_REST_DELTA, 16'd0);
    reg_write(CFG_PITCH_BOTTOM, 16'd5760);
    reg_write(CFG_PITCH_TOP, 16'd0);
    reg_write(CFG_ROLL_LIMIT, 16'd0);
    reg_write(CFG_AXIS_LOW, 16'h7FFF);
    reg_write(CFG_AXIS_HIGH, 16'h8000);
    random_part(30);
    idle_out();

    // register fields out of their documented range
    reg_write(CFG_REST_DELTA, 16'h7FFF);
    reg_write(CFG_PITCH_BOTTOM, 16'h1FFF);
    reg_write(CFG_PITCH_TOP, 16'h1FFF);
    reg_write(CFG_ROLL_LIMIT, 16'h1FFF);
    random_part(20);
    idle_out();

    repeat (5) begin
      reg_write(CFG_TIMEOUT, $urandom_range(1, 6));
      reg_write(CFG_REST_DELTA, $urandom_range(50, 400));
      reg_write(CFG_PITCH_BOTTOM, $urandom_range(600, 2000));
      reg_write(CFG_PITCH_TOP, $urandom_range(4000, 5760));
      reg_write(CFG_ROLL_LIMIT, $urandom_range(300, 1500));
      reg_write(CFG_AXIS_LOW, $urandom_range(700, 1200));
      reg_write(CFG_AXIS_HIGH, $urandom_range(2300, 3000));
      random_part(60);
      idle_out();
    end

    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
